// ===== src/secure_beacon_iv_tracker_macros.svh =====
// assertion macros for the secure beacon iv tracker
`ifndef SECURE_BEACON_IV_TRACKER_MACROS_SVH
`define SECURE_BEACON_IV_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define SBIT_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// checked at every edge, reset included
`define SBIT_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define SBIT_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define SBIT_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ===== src/sbit_pkg.sv =====
// shared types, constants and tables of the secure beacon iv tracker
`timescale 1ns / 1ps

package sbit_pkg;

  localparam int RING_DEPTH     = 8;
  localparam int PERIOD_S       = 20;
  localparam int EXPECTED_COUNT = 2;
  localparam int IV_WINDOW      = 48;
  localparam int MS_PER_S       = 1000;
  localparam int INTERVAL_MAX   = 131071;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int TS_W    = 16;
  localparam int TAG_W   = 64;
  localparam int IV_W    = 32;
  localparam int INTV_W  = 17;
  localparam int UPC_W   = 4;

  typedef enum logic [1:0] {
    OP_BEACON = 2'd0,
    OP_TIMER  = 2'd1,
    OP_START  = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_START_UPD = 2'd1,
    ACT_RECOVER   = 2'd2,
    ACT_STOP_UPD  = 2'd3
  } action_t;

  // datapath operation of one microcode step
  typedef enum logic [3:0] {
    DP_LOAD,
    DP_BCMP,
    DP_BACT,
    DP_BREC,
    DP_CLEAR,
    DP_WINIT,
    DP_WALK,
    DP_INTV,
    DP_HOLD
  } dp_op_t;

  // sequencing of one microcode step
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_FETCH,
    J_IF,
    J_EMIT
  } jmp_t;

  typedef struct packed {
    dp_op_t             op;
    jmp_t               jmp;
    logic [UPC_W-1:0]   target;
  } ctrl_word_t;

  typedef struct packed {
    op_t               operation;
    logic [TS_W-1:0]   now_seconds;
    logic              net_id_match;
    logic              auth_valid;
    logic [TAG_W-1:0]  auth_tag;
    logic              beacon_update_flag;
    logic [IV_W-1:0]   beacon_iv;
    logic [IV_W-1:0]   local_iv;
  } item_t;

  typedef struct packed {
    action_t             iv_action;
    logic [IV_W-1:0]     recover_value;
    logic                recorded;
    logic [INTV_W-1:0]   interval_ms;
  } result_t;

  // interval per beacon count, worked out at elaboration
  typedef logic [INTV_W-1:0] intv_tbl_t [RING_DEPTH+1];

  function automatic intv_tbl_t build_intv_tbl();
    intv_tbl_t tbl;
    longint    ms;
    for (int k = 0; k <= RING_DEPTH; k++) begin
      ms = ((longint'(PERIOD_S) * k) / EXPECTED_COUNT) * MS_PER_S;
      if (ms > INTERVAL_MAX) begin
        ms = INTERVAL_MAX;
      end
      tbl[k] = INTV_W'(ms);
    end
    return tbl;
  endfunction

  localparam intv_tbl_t INTV_TBL = build_intv_tbl();

endpackage

// ===== src/secure_beacon_iv_tracker.sv =====
// top level of the secure beacon iv tracker: stream ports, sequencer, datapath, output register
// steps: a beacon is compared, gets its action and is recorded unless rejected or stale;
// a timer reads the newest stamp, walks back reading one ring entry per cycle, then looks up
// the interval; start clears the ring, then runs the timer steps; the unused code goes straight
// to the result; one word is worked at a time: the next input word is taken the cycle after the
// result moves into the output register; rst_n is synchronous, active low: clears the step
// counter, ring valid bits, write slot, cached tag and output valid; the ring reads as all zero after reset
`timescale 1ns / 1ps
`include "secure_beacon_iv_tracker_macros.svh"

module secure_beacon_iv_tracker import sbit_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[1:0]
  input  logic [1:0]   in_tuser,
  // now_seconds[15:0], net_id_match[16], auth_valid[17], auth_tag[81:18],
  // beacon_update_flag[82], beacon_iv[114:83], local_iv[146:115], zero pad[151:147]
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // iv_action[1:0], recover_value[33:2], recorded[34], interval_ms[51:35], zero pad[55:52]
  output logic [55:0]  out_tdata
);

  ctrl_word_t cw;
  item_t      in_item;
  result_t    res;
  result_t    out_r,       out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_accept;
  logic       out_free;
  logic       emit;
  logic       dp_flag;

  // unpack the input word
  assign in_item.operation          = op_t'(in_tuser);
  assign in_item.now_seconds        = in_tdata[15:0];
  assign in_item.net_id_match       = in_tdata[16];
  assign in_item.auth_valid         = in_tdata[17];
  assign in_item.auth_tag           = in_tdata[81:18];
  assign in_item.beacon_update_flag = in_tdata[82];
  assign in_item.beacon_iv          = in_tdata[114:83];
  assign in_item.local_iv           = in_tdata[146:115];

  assign in_accept = in_tvalid && in_tready;
  // the output register can take a result when empty or being drained
  assign out_free  = !out_valid_r || out_tready;

  sbit_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_op     (in_item.operation),
    .out_free  (out_free),
    .dp_flag   (dp_flag),
    .cw        (cw),
    .in_ready  (in_tready),
    .emit      (emit)
  );

  sbit_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cw        (cw),
    .in_accept (in_accept),
    .in_item   (in_item),
    .dp_flag   (dp_flag),
    .res       (res)
  );

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r.interval_ms, out_r.recorded, out_r.recover_value,
                       out_r.iv_action};

  // one word in flight: no new word right after an accept
  `SBIT_ASSERT(a_one_in_flight, clk, rst_n, in_accept |=> !in_tready, "word accepted while busy")
  // recorded beacons never carry an interval
  `SBIT_ASSERT(a_rec_no_intv, clk, rst_n, (out_valid_r && out_r.recorded) |-> (out_r.interval_ms == '0), "recorded result has interval")
  // recover value only with the recover action
  `SBIT_ASSERT(a_recover_val, clk, rst_n, (out_valid_r && (out_r.iv_action != ACT_RECOVER)) |-> (out_r.recover_value == '0), "recover value without recover action")
  // interval results carry no beacon action
  `SBIT_ASSERT(a_intv_no_act, clk, rst_n, (out_valid_r && (out_r.interval_ms != '0)) |-> ((out_r.iv_action == ACT_NONE) && !out_r.recorded), "interval result with beacon fields")
  // nothing leaves right after reset
  `SBIT_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

// ===== src/sbit_seq.sv =====
// microcode sequencer: step counter, control rom and jump logic
`timescale 1ns / 1ps

module sbit_seq import sbit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  op_t        in_op,
  input  logic       out_free,
  input  logic       dp_flag,
  output ctrl_word_t cw,
  output logic       in_ready,
  output logic       emit
);

  localparam logic [UPC_W-1:0] UPC_FETCH = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_BCMP  = UPC_W'(1);
  localparam logic [UPC_W-1:0] UPC_BACT  = UPC_W'(2);
  localparam logic [UPC_W-1:0] UPC_BREC  = UPC_W'(3);
  localparam logic [UPC_W-1:0] UPC_CLEAR = UPC_W'(4);
  localparam logic [UPC_W-1:0] UPC_WINIT = UPC_W'(5);
  localparam logic [UPC_W-1:0] UPC_WALK  = UPC_W'(6);
  localparam logic [UPC_W-1:0] UPC_INTV  = UPC_W'(7);
  localparam logic [UPC_W-1:0] UPC_DONE  = UPC_W'(8);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;

  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_word_t w;
    unique case (addr)
      UPC_FETCH: w = '{op: DP_LOAD,  jmp: J_FETCH, target: UPC_FETCH};
      UPC_BCMP:  w = '{op: DP_BCMP,  jmp: J_NEXT,  target: UPC_FETCH};
      UPC_BACT:  w = '{op: DP_BACT,  jmp: J_IF,    target: UPC_DONE};
      UPC_BREC:  w = '{op: DP_BREC,  jmp: J_GOTO,  target: UPC_DONE};
      UPC_CLEAR: w = '{op: DP_CLEAR, jmp: J_NEXT,  target: UPC_FETCH};
      UPC_WINIT: w = '{op: DP_WINIT, jmp: J_NEXT,  target: UPC_FETCH};
      UPC_WALK:  w = '{op: DP_WALK,  jmp: J_IF,    target: UPC_WALK};
      UPC_INTV:  w = '{op: DP_INTV,  jmp: J_NEXT,  target: UPC_FETCH};
      UPC_DONE:  w = '{op: DP_HOLD,  jmp: J_EMIT,  target: UPC_FETCH};
      default:   w = '{op: DP_HOLD,  jmp: J_GOTO,  target: UPC_FETCH};
    endcase
    return w;
  endfunction

  // entry step of each operation
  function automatic logic [UPC_W-1:0] dispatch(input op_t op);
    logic [UPC_W-1:0] a;
    unique case (op)
      OP_BEACON: a = UPC_BCMP;
      OP_TIMER:  a = UPC_WINIT;
      OP_START:  a = UPC_CLEAR;
      OP_RSVD:   a = UPC_DONE;
      default:   a = UPC_DONE;
    endcase
    return a;
  endfunction

  assign cw       = ucode(upc_r);
  assign in_ready = (cw.jmp == J_FETCH);
  assign emit     = (cw.jmp == J_EMIT) && out_free;

  always_comb begin
    upc_nxt = upc_r;
    unique case (cw.jmp)
      J_NEXT:  upc_nxt = upc_r + UPC_W'(1);
      J_GOTO:  upc_nxt = cw.target;
      J_FETCH: upc_nxt = in_accept ? dispatch(in_op) : upc_r;
      J_IF:    upc_nxt = dp_flag ? cw.target : upc_r + UPC_W'(1);
      J_EMIT:  upc_nxt = out_free ? cw.target : upc_r;
      default: upc_nxt = UPC_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== src/sbit_dp.sv =====
// datapath: item register, iv compares, tag cache, timestamp ring and walk counter
`timescale 1ns / 1ps

module sbit_dp import sbit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_word_t cw,
  input  logic       in_accept,
  input  item_t      in_item,
  output logic       dp_flag,
  output result_t    res
);

  item_t                  item_r,     item_nxt;
  result_t                res_r,      res_nxt;
  logic [TAG_W-1:0]       last_tag_r, last_tag_nxt;
  logic [TS_W-1:0]        ts_r   [RING_DEPTH];
  logic [TS_W-1:0]        ts_nxt [RING_DEPTH];
  logic [RING_DEPTH-1:0]  vld_r,      vld_nxt;
  logic [RING_AW-1:0]     wpos_r,     wpos_nxt;
  logic [RING_AW-1:0]     j_r,        j_nxt;
  logic [CNT_W-1:0]       i_r,        i_nxt;
  logic [TS_W-1:0]        newest_r,   newest_nxt;
  logic                   gate_r,     gate_nxt;
  logic                   eq1_r,      eq1_nxt;
  logic                   win_r,      win_nxt;
  logic                   eq0_r,      eq0_nxt;
  logic                   stale_r,    stale_nxt;

  logic [IV_W:0]          b33, l33, l_plus1, l_plus_win, b_plus_win;
  logic [RING_AW-1:0]     newest_idx, rd_idx;
  logic [TS_W-1:0]        rd_val, age;
  logic                   walk_more;
  action_t                act;

  assign b33        = {1'b0, item_r.beacon_iv};
  assign l33        = {1'b0, item_r.local_iv};
  assign l_plus1    = l33 + (IV_W+1)'(1);
  assign l_plus_win = l33 + (IV_W+1)'(IV_WINDOW);
  assign b_plus_win = b33 + (IV_W+1)'(IV_WINDOW);

  assign newest_idx = (wpos_r == '0) ? RING_AW'(RING_DEPTH - 1) : wpos_r - RING_AW'(1);
  // one ring read port: newest entry at walk start, older entries during the walk
  assign rd_idx     = (cw.op == DP_WINIT) ? newest_idx : j_r;
  assign rd_val     = vld_r[rd_idx] ? ts_r[rd_idx] : '0;
  assign age        = newest_r - rd_val;
  assign walk_more  = (i_r != CNT_W'(RING_DEPTH)) && vld_r[j_r] && (age <= TS_W'(PERIOD_S));

  always_comb begin
    act = ACT_NONE;
    if (eq1_r) begin
      act = item_r.beacon_update_flag ? ACT_START_UPD : ACT_RECOVER;
    end
    if (win_r) begin
      act = ACT_RECOVER;
    end
    if (eq0_r) begin
      act = ACT_STOP_UPD;
    end
  end

  always_comb begin
    item_nxt     = item_r;
    res_nxt      = res_r;
    last_tag_nxt = last_tag_r;
    ts_nxt       = ts_r;
    vld_nxt      = vld_r;
    wpos_nxt     = wpos_r;
    j_nxt        = j_r;
    i_nxt        = i_r;
    newest_nxt   = newest_r;
    gate_nxt     = gate_r;
    eq1_nxt      = eq1_r;
    win_nxt      = win_r;
    eq0_nxt      = eq0_r;
    stale_nxt    = stale_r;
    dp_flag      = 1'b0;
    unique case (cw.op)
      DP_LOAD: begin
        if (in_accept) begin
          item_nxt = in_item;
          res_nxt  = '0;
        end
      end
      DP_BCMP: begin
        gate_nxt  = item_r.net_id_match && item_r.auth_valid
                    && (item_r.auth_tag != last_tag_r);
        eq1_nxt   = (b33 == l_plus1);
        win_nxt   = (b33 > l_plus1) && (b33 < l_plus_win);
        eq0_nxt   = !item_r.beacon_update_flag && (b33 == l33);
        stale_nxt = (b_plus_win < l33);
      end
      DP_BACT: begin
        // rejected or stale beacons skip the record step
        dp_flag = !gate_r || stale_r;
        if (gate_r) begin
          res_nxt.iv_action     = act;
          res_nxt.recover_value = (act == ACT_RECOVER) ? item_r.beacon_iv : '0;
        end
      end
      DP_BREC: begin
        last_tag_nxt     = item_r.auth_tag;
        ts_nxt[wpos_r]   = item_r.now_seconds;
        vld_nxt[wpos_r]  = 1'b1;
        wpos_nxt         = (wpos_r == RING_AW'(RING_DEPTH - 1)) ? '0 : wpos_r + RING_AW'(1);
        res_nxt.recorded = 1'b1;
      end
      DP_CLEAR: begin
        vld_nxt = '0;
      end
      DP_WINIT: begin
        newest_nxt = rd_val;
        j_nxt      = (newest_idx == '0) ? RING_AW'(RING_DEPTH - 1) : newest_idx - RING_AW'(1);
        i_nxt      = CNT_W'(1);
      end
      DP_WALK: begin
        dp_flag = walk_more;
        if (walk_more) begin
          i_nxt = i_r + CNT_W'(1);
          j_nxt = (j_r == '0) ? RING_AW'(RING_DEPTH - 1) : j_r - RING_AW'(1);
        end
      end
      DP_INTV: begin
        res_nxt.interval_ms = INTV_TBL[i_r];
      end
      DP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      wpos_r     <= '0;
      last_tag_r <= '0;
    end else begin
      vld_r      <= vld_nxt;
      wpos_r     <= wpos_nxt;
      last_tag_r <= last_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    ts_r     <= ts_nxt;
    j_r      <= j_nxt;
    i_r      <= i_nxt;
    newest_r <= newest_nxt;
    gate_r   <= gate_nxt;
    eq1_r    <= eq1_nxt;
    win_r    <= win_nxt;
    eq0_r    <= eq0_nxt;
    stale_r  <= stale_nxt;
  end

endmodule

// ===== tb/testbench.sv =====
// self-checking stream testbench for the secure beacon iv tracker
`timescale 1ns / 1ps

module testbench;
  import sbit_pkg::*;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser   = '0;
  logic [151:0] in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;

  secure_beacon_iv_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // idling percentages of the current phase
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int          fail_count     = 0;

  // predicted tracker state
  logic [15:0] stamp_ring [RING_DEPTH];
  logic        stamp_valid [RING_DEPTH];
  int          stamp_wpos;
  logic [63:0] cached_tag;

  // results still owed by the block, oldest first
  result_t expected_results [$];
  result_t seen_result;
  result_t oldest_result;

  // interval from the count of recent stamps, walking back from the newest
  function automatic logic [INTV_W-1:0] beacon_interval_ms();
    int          newest;
    int          slot;
    int          cnt;
    bit          stop;
    logic [15:0] age;
    longint      ms;
    newest = (stamp_wpos + RING_DEPTH - 1) % RING_DEPTH;
    cnt    = 1;
    stop   = 1'b0;
    for (int i = 1; i < RING_DEPTH; i++) begin
      if (!stop) begin
        slot = (newest + RING_DEPTH - i) % RING_DEPTH;
        age  = stamp_ring[newest] - stamp_ring[slot];
        if (!stamp_valid[slot] || age > PERIOD_S) begin
          stop = 1'b1;
        end else begin
          cnt = i + 1;
        end
      end
    end
    ms = ((longint'(PERIOD_S) * cnt) / EXPECTED_COUNT) * MS_PER_S;
    if (ms > INTERVAL_MAX) begin
      ms = INTERVAL_MAX;
    end
    return INTV_W'(ms);
  endfunction

  // advance the predicted state by one word and return the result it owes
  function automatic result_t track_item(item_t it);
    result_t     r;
    action_t     act;
    logic [33:0] b;
    logic [33:0] l;
    r = '0;
    b = {2'b00, it.beacon_iv};
    l = {2'b00, it.local_iv};
    case (it.operation)
      OP_BEACON: begin
        // gates: matching network, passed authentication, tag not seen last
        if (it.net_id_match && it.auth_valid && it.auth_tag != cached_tag) begin
          act = ACT_NONE;
          if (b == l + 34'd1) begin
            act = it.beacon_update_flag ? ACT_START_UPD : ACT_RECOVER;
          end
          if (b > l + 34'd1 && b < l + 34'(IV_WINDOW)) begin
            act = ACT_RECOVER;
          end
          if (!it.beacon_update_flag && b == l) begin
            act = ACT_STOP_UPD;
          end
          r.iv_action     = act;
          r.recover_value = (act == ACT_RECOVER) ? it.beacon_iv : '0;
          // stale beacons leave the tag cache and the ring alone
          if (!(b + 34'(IV_WINDOW) < l)) begin
            cached_tag              = it.auth_tag;
            stamp_ring[stamp_wpos]  = it.now_seconds;
            stamp_valid[stamp_wpos] = 1'b1;
            stamp_wpos              = (stamp_wpos + 1) % RING_DEPTH;
            r.recorded              = 1'b1;
          end
        end
      end
      OP_TIMER: begin
        r.interval_ms = beacon_interval_ms();
      end
      OP_START: begin
        // write slot and tag cache survive the clear
        for (int i = 0; i < RING_DEPTH; i++) begin
          stamp_ring[i]  = '0;
          stamp_valid[i] = 1'b0;
        end
        r.interval_ms = beacon_interval_ms();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic item_t make_beacon(logic [15:0] now, logic id_ok, logic auth_ok,
                                        logic [63:0] tag, logic flag,
                                        logic [31:0] biv, logic [31:0] liv);
    item_t it;
    it.operation          = OP_BEACON;
    it.now_seconds        = now;
    it.net_id_match       = id_ok;
    it.auth_valid         = auth_ok;
    it.auth_tag           = tag;
    it.beacon_update_flag = flag;
    it.beacon_iv          = biv;
    it.local_iv           = liv;
    return it;
  endfunction

  // non-beacon word, the unused fields carry random bits
  function automatic item_t make_cmd(op_t op, logic [15:0] now);
    item_t it;
    it = make_beacon(now, 1'($urandom), 1'($urandom), {$urandom, $urandom},
                     1'($urandom), $urandom, $urandom);
    it.operation = op;
    return it;
  endfunction

  // receiver side: stall at random, decided at the falling edge
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  // result checker: each accepted word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result.iv_action     = action_t'(out_tdata[1:0]);
      seen_result.recover_value = out_tdata[33:2];
      seen_result.recorded      = out_tdata[34];
      seen_result.interval_ms   = out_tdata[51:35];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (seen_result.iv_action != oldest_result.iv_action) begin
          $display("%0t: iv_action expected %0d actual %0d", $time,
                   oldest_result.iv_action, seen_result.iv_action);
          fail_count++;
        end
        if (seen_result.recover_value != oldest_result.recover_value) begin
          $display("%0t: recover_value expected %h actual %h", $time,
                   oldest_result.recover_value, seen_result.recover_value);
          fail_count++;
        end
        if (seen_result.recorded != oldest_result.recorded) begin
          $display("%0t: recorded expected %0d actual %0d", $time,
                   oldest_result.recorded, seen_result.recorded);
          fail_count++;
        end
        if (seen_result.interval_ms != oldest_result.interval_ms) begin
          $display("%0t: interval_ms expected %0d actual %0d", $time,
                   oldest_result.interval_ms, seen_result.interval_ms);
          fail_count++;
        end
      end
    end
  end

  // drive one word from a falling edge, return at the falling edge after its accept;
  // tvalid stays high so a following word can go out back to back
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = it.operation;
    in_tdata  = {5'b0, it.local_iv, it.beacon_iv, it.beacon_update_flag, it.auth_tag,
                 it.auth_valid, it.net_id_match, it.now_seconds};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    expected_results.push_back(track_item(it));
    @(negedge clk);
  endtask

  // stop sending and wait for every owed result
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // empty ring, rejected beacons and the unused operation code
  task automatic test_gates();
    send_item(make_cmd(OP_TIMER, 16'd0));
    // tag equal to the cached tag, zero right after reset
    send_item(make_beacon(16'd1, 1'b1, 1'b1, 64'd0, 1'b1, 32'd11, 32'd10));
    send_item(make_beacon(16'd1, 1'b0, 1'b1, 64'h1, 1'b1, 32'd11, 32'd10));
    send_item(make_beacon(16'd1, 1'b1, 1'b0, 64'h2, 1'b1, 32'd11, 32'd10));
    send_item(make_cmd(OP_RSVD, 16'hffff));
  endtask

  // every iv decision and its boundaries, all stamped at second zero
  task automatic test_iv_actions();
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h10, 1'b1, 32'd1001, 32'd1000));
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h11, 1'b0, 32'd1001, 32'd1000));
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h12, 1'b1, 32'd1047, 32'd1000));
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h13, 1'b1, 32'd1048, 32'd1000));
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h14, 1'b0, 32'd1000, 32'd1000));
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h15, 1'b1, 32'd1000, 32'd1000));
    // stale by one, then exactly at the window edge
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h16, 1'b0, 32'd51, 32'd100));
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h17, 1'b0, 32'd52, 32'd100));
    // beacon iv zero against the top local iv: no 32-bit wrap in the compare
    send_item(make_beacon(16'd0, 1'b1, 1'b1, 64'h18, 1'b1, 32'd0, 32'hffff_ffff));
    send_item(make_beacon(16'd0, 1'b1, 1'b1, '1, 1'b1, 32'hffff_ffff, 32'hffff_fffe));
    // same tag again is dropped
    send_item(make_beacon(16'd0, 1'b1, 1'b1, '1, 1'b1, 32'hffff_ffff, 32'hffff_fffe));
  endtask

  // full ring, seconds wrapping, start clearing the ring
  task automatic test_ring_interval();
    send_item(make_cmd(OP_TIMER, 16'd0));
    send_item(make_beacon(16'd65530, 1'b1, 1'b1, 64'h20, 1'b0, 32'd7, 32'd7));
    send_item(make_beacon(16'd65535, 1'b1, 1'b1, 64'h21, 1'b0, 32'd7, 32'd7));
    send_item(make_beacon(16'd3, 1'b1, 1'b1, 64'h22, 1'b0, 32'd7, 32'd7));
    send_item(make_cmd(OP_TIMER, 16'd3));
    send_item(make_cmd(OP_START, 16'd4));
    send_item(make_cmd(OP_TIMER, 16'd5));
  endtask

  // random words, mostly well-formed beacons with a running seconds counter
  task automatic run_random(int n_items);
    item_t       it;
    int          useful;
    int unsigned pick;
    logic [15:0] secs;
    logic [31:0] liv;
    logic [31:0] biv;
    useful = 0;
    secs   = 16'($urandom);
    while (useful < n_items) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        secs = 16'($urandom);
      end else if (pick < 10) begin
        secs = secs + 16'($urandom_range(15, 40));
      end else begin
        secs = secs + 16'($urandom_range(0, 4));
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        case ($urandom_range(7))
          0:       liv = 32'hffff_ffff - $urandom_range(0, 60);
          1:       liv = $urandom_range(0, 60);
          default: liv = $urandom;
        endcase
        case ($urandom_range(8))
          0:       biv = liv + 32'd1;
          1:       biv = liv + $urandom_range(2, 47);
          2:       biv = liv;
          3:       biv = liv + $urandom_range(48, 200);
          4:       biv = liv - $urandom_range(0, 48);
          5:       biv = liv - $urandom_range(49, 1000);
          6:       biv = liv + 32'd47;
          7:       biv = liv - 32'd48;
          default: biv = $urandom;
        endcase
        it = make_beacon(secs, 1'b1, 1'b1, {$urandom, $urandom}, 1'($urandom), biv, liv);
        useful++;
      end else if (pick < 78) begin
        it = make_cmd(OP_TIMER, secs);
        useful++;
      end else if (pick < 83) begin
        it = make_cmd(OP_START, secs);
        useful++;
      end else if (pick < 86) begin
        it = make_cmd(OP_RSVD, secs);
      end else begin
        // broken beacons: one gate failing, or fully random content
        it = make_cmd(OP_BEACON, secs);
        case ($urandom_range(3))
          0:       it.net_id_match = 1'b0;
          1:       it.auth_valid = 1'b0;
          2:       it.auth_tag = cached_tag;
          default: ;
        endcase
      end
      send_item(it);
    end
  endtask

  task automatic test_no_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_random(300);
    drain_results();
  endtask

  task automatic test_sender_idle();
    src_idle_pct   = 45;
    sink_stall_pct = 0;
    run_random(300);
    drain_results();
  endtask

  task automatic test_receiver_stall();
    src_idle_pct   = 0;
    sink_stall_pct = 45;
    run_random(300);
    drain_results();
  endtask

  task automatic test_both_idle();
    src_idle_pct   = 33;
    sink_stall_pct = 33;
    run_random(300);
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      stamp_ring[i]  = '0;
      stamp_valid[i] = 1'b0;
    end
    stamp_wpos = 0;
    cached_tag = '0;

    // synchronous reset, released at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_gates();
    test_iv_actions();
    test_ring_interval();
    drain_results();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();

    // give stray words time to show up
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("secure_beacon_iv_tracker: match");
    end else begin
      $display("secure_beacon_iv_tracker: mismatch");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("secure_beacon_iv_tracker: mismatch");
    $finish;
  end

endmodule
